### rtl/tsni_pkg.sv
// Package for the TLS ClientHello server-name extractor.
// Holds the transaction payload types and the sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package tsni_pkg;

  localparam int unsigned CHUNK_BYTES       = 16384;
  localparam int unsigned NAME_BUFFER_BYTES = 256;
  localparam int unsigned POS_W             = 17;
  localparam logic [POS_W-1:0] TARGET_MAX   = 17'h1FFFF;

  localparam logic [7:0]  REC_TYPE_HANDSHAKE = 8'h16;
  localparam logic [7:0]  HS_TYPE_CLIENT_HELLO = 8'h01;
  localparam logic [15:0] EXT_SERVER_NAME    = 16'h0000;
  localparam logic [7:0]  NAME_TYPE_HOST     = 8'h00;
  // record header (5) + handshake header (4) + version (2) + random (32)
  localparam logic [POS_W-1:0] SID_LEN_POS   = POS_W'(5 + 4 + 2 + 32);
  localparam logic [POS_W-1:0] HS_TYPE_POS   = POS_W'(5);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_chunk;
  } in_t;

  typedef struct packed {
    logic [7:0] host_byte;
    logic       host_byte_valid;
    logic       parse_done;
    logic       sni_found;
  } out_t;

endpackage

### rtl/tls_sni_hostname_extract_unit.sv
// An accepted byte goes into the input register and is parsed from it into the result
// register, where its result is offered. Throughput: one byte per cycle; a result held by
// the receiver holds the input register and drops in_ready. Bytes that produce no result
// are consumed silently. Reset (rst_n low, synchronous) empties both registers and returns
// the parser to the record header phase with all counters zero.
// Top level of the TLS ClientHello server-name extractor; uses tsni_pkg.
`timescale 1ns / 1ps

module tls_sni_hostname_extract_unit
  import tsni_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Parser phases, one-hot.
  typedef enum logic [15:0] {
    PH_REC_TYPE  = 16'h0001,
    PH_HS_TYPE   = 16'h0002,
    PH_SID_LEN   = 16'h0004,
    PH_CS_HI     = 16'h0008,
    PH_CS_LO     = 16'h0010,
    PH_COMP_LEN  = 16'h0020,
    PH_EXT_HI    = 16'h0040,
    PH_EXT_LO    = 16'h0080,
    PH_ET_HI     = 16'h0100,
    PH_ET_LO     = 16'h0200,
    PH_EL_HI     = 16'h0400,
    PH_EL_LO     = 16'h0800,
    PH_NAME_TYPE = 16'h1000,
    PH_NL_HI     = 16'h2000,
    PH_NL_LO     = 16'h4000,
    PH_NAME      = 16'h8000
  } phase_t;

  localparam logic [POS_W-1:0] CHUNK_END  = POS_W'(CHUNK_BYTES);
  localparam logic [POS_W-1:0] CHUNK_LAST = POS_W'(CHUNK_BYTES - 1);
  localparam logic [15:0]      NAME_KEEP  = 16'(NAME_BUFFER_BYTES - 1);

  // Input register.
  logic in_valid_r;
  in_t  in_r;

  // Parse state.
  phase_t           phase_r,    phase_nxt;
  logic [POS_W-1:0] pos_r,      pos_nxt;
  logic [POS_W-1:0] skip_r,     skip_nxt;
  logic [7:0]       len_hi_r,   len_hi_nxt;
  logic [POS_W-1:0] ext_end_r,  ext_end_nxt;
  logic [15:0]      ext_type_r, ext_type_nxt;
  logic [15:0]      name_len_r, name_len_nxt;
  logic [15:0]      name_seen_r, name_seen_nxt;
  logic             given_r,    given_nxt;

  // Result register.
  logic out_valid_r;
  out_t out_r;

  logic advance;
  logic emit;
  out_t res;

  // Working values for the current byte.
  logic [7:0]       b;
  logic [15:0]      v16;
  logic [POS_W:0]   p1;        // pos + 1
  logic [POS_W:0]   p1_b;      // pos + 1 + byte
  logic [POS_W:0]   p1_v;      // pos + 1 + 16-bit length
  logic [POS_W:0]   p1_v4;     // pos + 1 + length + 4
  logic [POS_W:0]   p1_4;      // pos + 1 + 4
  logic [POS_W-1:0] ext_end_cap;
  logic [15:0]      name_seen_inc;
  logic             done, found, hv;

  function automatic logic [POS_W-1:0] sat_target(input logic [POS_W:0] val);
    sat_target = (val > {1'b0, TARGET_MAX}) ? TARGET_MAX : val[POS_W-1:0];
  endfunction

  // Advance the pipe whenever the result register is free or being drained.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign b             = in_r.data_byte;
  assign v16           = {len_hi_r, b};
  assign p1            = {1'b0, pos_r} + (POS_W+1)'(1);
  assign p1_b          = p1 + (POS_W+1)'(b);
  assign p1_v          = p1 + (POS_W+1)'(v16);
  assign p1_v4         = p1_v + (POS_W+1)'(4);
  assign p1_4          = p1 + (POS_W+1)'(4);
  assign ext_end_cap   = (p1_v > {1'b0, CHUNK_END}) ? CHUNK_END : p1_v[POS_W-1:0];
  assign name_seen_inc = name_seen_r + 16'd1;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    skip_nxt      = skip_r;
    len_hi_nxt    = len_hi_r;
    ext_end_nxt   = ext_end_r;
    ext_type_nxt  = ext_type_r;
    name_len_nxt  = name_len_r;
    name_seen_nxt = name_seen_r;
    given_nxt     = given_r;
    done          = 1'b0;
    found         = 1'b0;
    hv            = 1'b0;

    if (!given_r && pos_r < CHUNK_END) begin
      if (pos_r >= skip_r) begin
        unique case (phase_r)
          PH_REC_TYPE: begin
            if (b != REC_TYPE_HANDSHAKE) begin
              done = 1'b1;
            end else begin
              skip_nxt  = HS_TYPE_POS;
              phase_nxt = PH_HS_TYPE;
            end
          end
          PH_HS_TYPE: begin
            if (b != HS_TYPE_CLIENT_HELLO) begin
              done = 1'b1;
            end else begin
              skip_nxt  = SID_LEN_POS;
              phase_nxt = PH_SID_LEN;
            end
          end
          PH_SID_LEN: begin
            skip_nxt  = sat_target(p1_b);
            phase_nxt = PH_CS_HI;
          end
          PH_CS_HI: begin
            len_hi_nxt = b;
            phase_nxt  = PH_CS_LO;
          end
          PH_CS_LO: begin
            skip_nxt  = sat_target(p1_v);
            phase_nxt = PH_COMP_LEN;
          end
          PH_COMP_LEN: begin
            skip_nxt  = sat_target(p1_b);
            phase_nxt = PH_EXT_HI;
          end
          PH_EXT_HI: begin
            len_hi_nxt = b;
            phase_nxt  = PH_EXT_LO;
          end
          PH_EXT_LO: begin
            // Hold the list end clipped to the chunk bound.
            ext_end_nxt = ext_end_cap;
            if (p1_4 > {1'b0, ext_end_cap}) begin
              done = 1'b1;
            end else begin
              skip_nxt  = p1[POS_W-1:0];
              phase_nxt = PH_ET_HI;
            end
          end
          PH_ET_HI: begin
            len_hi_nxt = b;
            phase_nxt  = PH_ET_LO;
          end
          PH_ET_LO: begin
            ext_type_nxt = v16;
            phase_nxt    = PH_EL_HI;
          end
          PH_EL_HI: begin
            len_hi_nxt = b;
            phase_nxt  = PH_EL_LO;
          end
          PH_EL_LO: begin
            if (ext_type_r == EXT_SERVER_NAME) begin
              // Skip the two-byte server name list length.
              skip_nxt  = p1[POS_W-1:0] + POS_W'(2);
              phase_nxt = PH_NAME_TYPE;
            end else if (p1_v4 > {1'b0, ext_end_r}) begin
              done = 1'b1;
            end else begin
              skip_nxt  = p1_v[POS_W-1:0];
              phase_nxt = PH_ET_HI;
            end
          end
          PH_NAME_TYPE: begin
            if (b != NAME_TYPE_HOST) begin
              done = 1'b1;
            end else begin
              phase_nxt = PH_NL_HI;
            end
          end
          PH_NL_HI: begin
            len_hi_nxt = b;
            phase_nxt  = PH_NL_LO;
          end
          PH_NL_LO: begin
            name_len_nxt  = v16;
            name_seen_nxt = 16'd0;
            if (v16 == 16'd0) begin
              done = 1'b1;
            end else begin
              phase_nxt = PH_NAME;
            end
          end
          PH_NAME: begin
            hv            = (name_seen_r < NAME_KEEP);
            name_seen_nxt = name_seen_inc;
            if (name_seen_inc == name_len_r) begin
              done  = 1'b1;
              found = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      // Buffer bound reached without a decision.
      if (!done && pos_r == CHUNK_LAST) begin
        done = 1'b1;
      end
    end

    if (done) begin
      given_nxt = 1'b1;
    end
    // Early end of chunk: report not found on the final byte.
    if (in_r.end_of_chunk && !given_nxt) begin
      done  = 1'b1;
      found = 1'b0;
    end

    if (pos_r < CHUNK_END) begin
      pos_nxt = pos_r + POS_W'(1);
    end

    // Restart the parser after the final byte of a chunk.
    if (in_r.end_of_chunk) begin
      phase_nxt     = PH_REC_TYPE;
      pos_nxt       = '0;
      skip_nxt      = '0;
      len_hi_nxt    = '0;
      ext_end_nxt   = '0;
      ext_type_nxt  = '0;
      name_len_nxt  = '0;
      name_seen_nxt = '0;
      given_nxt     = 1'b0;
    end

    emit                = done || hv;
    res.host_byte       = hv ? b : 8'd0;
    res.host_byte_valid = hv;
    res.parse_done      = done;
    res.sni_found       = done && found;
  end

  // Input register: take a new transaction whenever the slot frees up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // Parse state advances once per consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_REC_TYPE;
      pos_r       <= '0;
      skip_r      <= '0;
      len_hi_r    <= '0;
      ext_end_r   <= '0;
      ext_type_r  <= '0;
      name_len_r  <= '0;
      name_seen_r <= '0;
      given_r     <= 1'b0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      skip_r      <= skip_nxt;
      len_hi_r    <= len_hi_nxt;
      ext_end_r   <= ext_end_nxt;
      ext_type_r  <= ext_type_nxt;
      name_len_r  <= name_len_nxt;
      name_seen_r <= name_seen_nxt;
      given_r     <= given_nxt;
    end
  end

  // Result register: load on a producing byte, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A held result always carries a name byte or the done indication.
  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.parse_done || out_r.host_byte_valid))
    else $error("empty result transaction");

  // Found is only ever reported together with done.
  a_found_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.sni_found) |-> out_r.parse_done)
    else $error("sni_found without parse_done");

  // The final byte of a chunk returns the parser to its start.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_r.end_of_chunk) |=>
      (phase_r == PH_REC_TYPE && pos_r == '0 && !given_r))
    else $error("parser did not restart after end of chunk");

  // The byte position saturates at the chunk bound.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CHUNK_END)
    else $error("byte position beyond chunk bound");

  // Once the result is given no further name bytes are emitted in the chunk.
  a_no_bytes_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && given_r) |=> !(out_valid_r && out_r.host_byte_valid))
    else $error("name byte after result");

endmodule
